// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the press detector RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SDP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SDP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/sdp_pkg.sv =====
// Package for the single/double press detector: transaction types, codes, helpers.
// No dependencies; imported by every module of the block.
`default_nettype none

package sdp_pkg;

	// input opcodes
	typedef enum logic [1:0] {
		OP_LEVEL   = 2'd0,
		OP_TICK    = 2'd1,
		OP_SUSPEND = 2'd2,
		OP_RESUME  = 2'd3
	} opcode_t;

	// configuration register indexes
	localparam logic CFG_DOUBLE_ENABLE = 1'b0;
	localparam logic CFG_WINDOW_TICKS  = 1'b1;

	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_DATA_W-1:0] WINDOW_RESET = 16'd200;

	// key codes
	localparam logic CODE_HOME = 1'b0;
	localparam logic CODE_DBL  = 1'b1;

	typedef struct packed {
		opcode_t opcode;
		logic    key_level;
	} cmd_t;

	typedef struct packed {
		logic key_code;
		logic key_value;
		logic last_event;
	} evt_t;

	// results of one processed command: count 0..2, first then second
	typedef struct packed {
		logic [1:0] count;
		evt_t       first;
		evt_t       second;
	} evt_pair_t;

	function automatic evt_t mk_evt(input logic code, input logic value, input logic last);
		evt_t e;
		e.key_code   = code;
		e.key_value  = value;
		e.last_event = last;
		return e;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/single_double_press_detector_unit.sv =====
// Top level of the single/double press detector: input register, engine, result buffer.
// Depends on sdp_pkg, sdp_engine, sdp_evbuf and assert_macros.svh.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd): one transaction per command: level change,
//   tick, suspend or resume, with the key level for level changes.
//   evt channel (evt_valid/evt_ready/evt): zero, one or two key events per command;
//   last_event marks the final event of a command.
//   cfg port: cfg_we with cfg_index (0 double_enable, 1 window_ticks) and cfg_data,
//   taken on the same edge; write only while no command is in flight.
// Flow: a command waits in the input register until the result buffer is free; it is
//   then processed, and its first event is valid on evt right after that edge.
// Throughput: one command per cycle while evt_ready is high and commands give at most
//   one event each; a two-event command holds the single result port until both leave.
// Reset: arst_n clears the detector state, empties the pipeline and loads the
//   registers with their defaults (detection off, 200-tick window). No clearing pass.
// Stall: when evt_ready is low the result buffer keeps its events, the input
//   register holds one more command, and cmd_ready drops only once both are full.
`default_nettype none

module single_double_press_detector_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_valid,
	output logic                               cmd_ready,
	input  wire sdp_pkg::cmd_t                 cmd,
	output logic                               evt_valid,
	input  wire logic                          evt_ready,
	output sdp_pkg::evt_t                      evt,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [sdp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sdp_pkg::*;
	`include "assert_macros.svh"

	logic      valid_s1;
	cmd_t      cmd_s1;
	logic      buf_free;
	logic      advance;
	evt_pair_t res;

	assign advance   = valid_s1 && buf_free;
	assign cmd_ready = !valid_s1 || buf_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	sdp_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_s1    (cmd_s1),
		.advance   (advance),
		.res       (res)
	);

	sdp_evbuf u_evbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res       (res),
		.free      (buf_free),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt)
	);

	// a held command is not dropped while the buffer is busy
	`SDP_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !buf_free,
		valid_s1 && $stable(cmd_s1), "input register lost a pending command")

endmodule

`default_nettype wire

// ===== hdl/sdp_engine.sv =====
// Press detector engine: config registers, detector state and the per-command step.
// Depends on sdp_pkg and assert_macros.svh.
`default_nettype none

module sdp_engine (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [sdp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire sdp_pkg::cmd_t                 cmd_s1,
	input  wire logic                          advance,
	output sdp_pkg::evt_pair_t                 res
);
	import sdp_pkg::*;
	`include "assert_macros.svh"

	typedef struct packed {
		logic        pressed;
		logic [1:0]  press_count;
		logic        release_owed;
		logic [15:0] window_left;
		logic        suspended;
	} state_t;

	logic        double_enable_q;
	logic [15:0] window_ticks_q;
	state_t      st_q;
	state_t      st_nxt;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			double_enable_q <= 1'b0;
			window_ticks_q  <= WINDOW_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DOUBLE_ENABLE: double_enable_q <= cfg_data[0];
				CFG_WINDOW_TICKS:  window_ticks_q  <= cfg_data[15:0];
				default:           ;
			endcase
		end
	end

	// one command step: next state and up to two events
	always_comb begin
		st_nxt = st_q;
		res    = '0;
		unique case (cmd_s1.opcode)
			OP_LEVEL: begin
				if (st_q.suspended && cmd_s1.key_level) begin
					res.count      = 2'd2;
					res.first      = mk_evt(CODE_HOME, 1'b1, 1'b0);
					res.second     = mk_evt(CODE_HOME, 1'b0, 1'b1);
					st_nxt.pressed = 1'b0;
				end else if (st_q.pressed != cmd_s1.key_level) begin
					st_nxt.pressed = cmd_s1.key_level;
					if (double_enable_q) begin
						if (cmd_s1.key_level) begin
							// first press opens the window; zero length means one tick
							if (st_q.press_count == 2'd0)
								st_nxt.window_left = (window_ticks_q == 16'd0) ? 16'd1
									: window_ticks_q;
							if (st_q.press_count != 2'd3)
								st_nxt.press_count = st_q.press_count + 2'd1;
						end else if (st_q.release_owed) begin
							res.count           = 2'd1;
							res.first           = mk_evt(CODE_HOME, 1'b0, 1'b1);
							st_nxt.release_owed = 1'b0;
						end
					end else begin
						res.count = 2'd1;
						res.first = mk_evt(CODE_HOME, cmd_s1.key_level, 1'b1);
					end
				end
			end
			OP_TICK: begin
				if (st_q.window_left != 16'd0) begin
					st_nxt.window_left = st_q.window_left - 16'd1;
					// window expiry: judge the count
					if (st_q.window_left == 16'd1) begin
						st_nxt.press_count = 2'd0;
						if (st_q.press_count > 2'd1) begin
							res.count  = 2'd2;
							res.first  = mk_evt(CODE_DBL, 1'b1, 1'b0);
							res.second = mk_evt(CODE_DBL, 1'b0, 1'b1);
						end else if (st_q.press_count == 2'd1) begin
							if (st_q.pressed) begin
								res.count           = 2'd1;
								res.first           = mk_evt(CODE_HOME, 1'b1, 1'b1);
								st_nxt.release_owed = 1'b1;
							end else begin
								res.count  = 2'd2;
								res.first  = mk_evt(CODE_HOME, 1'b1, 1'b0);
								res.second = mk_evt(CODE_HOME, 1'b0, 1'b1);
							end
						end
					end
				end
			end
			OP_SUSPEND: begin
				st_nxt.suspended = 1'b1;
				if (st_q.press_count != 2'd0) begin
					st_nxt.window_left = 16'd0;
					st_nxt.press_count = 2'd0;
					if (st_q.release_owed) begin
						res.count           = 2'd1;
						res.first           = mk_evt(CODE_HOME, 1'b0, 1'b1);
						st_nxt.release_owed = 1'b0;
					end
				end
			end
			OP_RESUME: begin
				st_nxt.suspended = 1'b0;
			end
			default: ;
		endcase
	end

	// detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// an open window always goes with a nonzero press count, and the reverse
	`SDP_ASSERT_NOW(a_window_count, clk, arst_n, 1'b1,
		(st_q.window_left != 16'd0) == (st_q.press_count != 2'd0),
		"window timer and press count disagree")

endmodule

`default_nettype wire

// ===== hdl/sdp_evbuf.sv =====
// Two-slot result buffer: takes up to two events per command, sends one per transaction.
// Depends on sdp_pkg and assert_macros.svh.
`default_nettype none

module sdp_evbuf (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire sdp_pkg::evt_pair_t res,
	output logic                    free,
	output logic                    evt_valid,
	input  wire logic               evt_ready,
	output sdp_pkg::evt_t           evt
);
	import sdp_pkg::*;
	`include "assert_macros.svh"

	logic [1:0] cnt_q;
	evt_t       slot0_q;
	evt_t       slot1_q;

	// free when empty, or when the last held event leaves this cycle
	assign free      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && evt_ready);
	assign evt_valid = (cnt_q != 2'd0);
	assign evt       = slot0_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res.count;
		end else if (evt_valid && evt_ready) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// payload slots
	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= res.first;
			slot1_q <= res.second;
		end else if ((cnt_q == 2'd2) && evt_ready) begin
			slot0_q <= slot1_q;
		end
	end

	`SDP_ASSERT_NOW(a_cnt_range, clk, arst_n, 1'b1, cnt_q != 2'd3,
		"result buffer holds more than two events")
	`SDP_ASSERT_NOW(a_last_marks, clk, arst_n, cnt_q != 2'd0,
		slot0_q.last_event == (cnt_q == 2'd1),
		"end-of-command mark out of place in result buffer")

endmodule

`default_nettype wire
